// ===== rtl/gaussian_prime_sieve_tester_top_assert.svh =====
// Assertion macros used by the Gaussian prime sieve tester engine.
`ifndef GAUSSIAN_PRIME_SIEVE_TESTER_TOP_ASSERT_SVH
`define GAUSSIAN_PRIME_SIEVE_TESTER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clock, quiet during reset.
`define GPST_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, quiet during reset.
`define GPST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gpst_pkg.sv =====
// Package with constants, types and helpers of the Gaussian prime sieve tester.
package gpst_pkg;

   localparam int MAX_SIDE     = 32;
   localparam int BITMAP_DEPTH = 2048;

   localparam int CFG_W   = 6;
   localparam int PART_W  = 6;
   localparam int NORM_W  = 12;
   localparam int ADDR_W  = $clog2(BITMAP_DEPTH);
   localparam int LIMIT_W = $clog2(BITMAP_DEPTH + 1);
   localparam int PROD_W  = 2 * PART_W + 1;
   localparam int LIM_CALC_W = (PROD_W > LIMIT_W) ? PROD_W : LIMIT_W;

   localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(10);
   localparam logic [NORM_W-1:0] NORM_MAX  = {NORM_W{1'b1}};
   localparam logic [1:0]        MOD4_PRIME_RES = 2'd3;

   localparam logic ACT_BUILD = 1'b0;
   localparam logic ACT_TEST  = 1'b1;

   typedef struct packed {
      logic [NORM_W-1:0] norm;
      logic [ADDR_W-1:0] probe_addr;
      logic              in_range;
      logic              shape_ok;
   } norm_info_type;

   // Sieve range 2*n*n for side n, with n and the range both clamped.
   function automatic logic [LIMIT_W-1:0] calc_limit(input logic [CFG_W-1:0] side);
      logic [LIM_CALC_W-1:0] s;
      logic [LIM_CALC_W-1:0] p;
      s = LIM_CALC_W'(side);
      if (s > LIM_CALC_W'(MAX_SIDE)) begin
         s = LIM_CALC_W'(MAX_SIDE);
      end
      p = (s * s) << 1;
      if (p > LIM_CALC_W'(BITMAP_DEPTH)) begin
         p = LIM_CALC_W'(BITMAP_DEPTH);
      end
      return p[LIMIT_W-1:0];
   endfunction

endpackage

// ===== rtl/gpst_if.sv =====
// Request and response channel interfaces of the Gaussian prime sieve tester.
interface gpst_req_if import gpst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [PART_W-1:0] real_part;
   logic [PART_W-1:0] imag_part;

   modport source (output valid, action, real_part, imag_part, input ready);
   modport sink (input valid, action, real_part, imag_part, output ready);
endinterface

interface gpst_rsp_if import gpst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              build_done;
   logic              is_gaussian_prime;
   logic              out_of_range;
   logic [NORM_W-1:0] norm_value;

   modport source (output valid, build_done, is_gaussian_prime, out_of_range, norm_value,
                   input ready);
   modport sink (input valid, build_done, is_gaussian_prime, out_of_range, norm_value,
                 output ready);
endinterface

// ===== rtl/gpst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gpst_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gpst_norm.sv =====
// Norm, lookup address and range check of one test candidate.
module gpst_norm import gpst_pkg::*; (
   input  logic [PART_W-1:0]  real_part,
   input  logic [PART_W-1:0]  imag_part,
   input  logic [LIMIT_W-1:0] sieved_limit,
   output norm_info_type      info
);

   logic [PROD_W-1:0]     norm_full;
   logic [PROD_W-1:0]     probe;
   logic [LIM_CALC_W-1:0] probe_wide;
   logic                  imag_nz;

   always_comb begin
      norm_full = PROD_W'(real_part) * PROD_W'(real_part)
                + PROD_W'(imag_part) * PROD_W'(imag_part);
      imag_nz   = (imag_part != '0);
      // on the real axis the lookup is a itself
      probe      = imag_nz ? norm_full : PROD_W'(real_part);
      probe_wide = LIM_CALC_W'(probe);

      info.norm       = (norm_full > PROD_W'(NORM_MAX)) ? NORM_MAX : norm_full[NORM_W-1:0];
      info.probe_addr = probe_wide[ADDR_W-1:0];
      info.in_range   = probe_wide < LIM_CALC_W'(sieved_limit);
      info.shape_ok   = imag_nz || (real_part[1:0] == MOD4_PRIME_RES);
   end

endmodule

// ===== rtl/gpst_engine.sv =====
// Sequencer for sieve builds and bitmap lookups, with the response register.
`include "gaussian_prime_sieve_tester_top_assert.svh"
module gpst_engine import gpst_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   gpst_req_if.sink            req_if,
   gpst_rsp_if.source          rsp_if,
   input  logic [CFG_W-1:0]    max_side,
   input  norm_info_type       info,
   output logic [LIMIT_W-1:0]  sieved_limit,
   output logic                ram_we,
   output logic [ADDR_W-1:0]   ram_waddr,
   output logic                ram_wdata,
   output logic                ram_re,
   output logic [ADDR_W-1:0]   ram_raddr,
   input  logic                ram_rdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_TEST, S_INIT, S_PICK, S_CHECK, S_STRIKE, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [LIMIT_W-1:0] lim_ff, lim_in;
   logic [LIMIT_W:0]   cnt_ff, cnt_in;
   logic [LIMIT_W-1:0] idx_ff, idx_in;
   logic [LIMIT_W:0]   sq_ff, sq_in;
   logic               oor_ff, oor_in;
   logic               shape_ff, shape_in;
   logic [NORM_W-1:0]  norm_ff, norm_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_build_ff, rsp_build_in;
   logic               rsp_prime_ff, rsp_prime_in;
   logic               rsp_oor_ff, rsp_oor_in;
   logic [NORM_W-1:0]  rsp_norm_ff, rsp_norm_in;

   logic req_accept;
   logic out_free;
   logic cnt_below;

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      lim_in       = lim_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      sq_in        = sq_ff;
      oor_in       = oor_ff;
      shape_in     = shape_ff;
      norm_in      = norm_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_build_in = rsp_build_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_oor_in   = rsp_oor_ff;
      rsp_norm_in  = rsp_norm_ff;

      ram_we    = 1'b0;
      ram_waddr = cnt_ff[ADDR_W-1:0];
      ram_wdata = 1'b0;
      ram_re    = 1'b0;
      ram_raddr = info.probe_addr;

      req_accept = req_if.valid && (state_ff == S_IDLE);
      out_free   = !rsp_valid_ff || rsp_if.ready;
      cnt_below  = cnt_ff < {1'b0, lim_ff};

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_if.action == ACT_TEST) begin
                  oor_in   = !info.in_range;
                  shape_in = info.shape_ok;
                  norm_in  = info.norm;
                  ram_re   = info.in_range;
                  state_in = S_TEST;
               end else begin
                  lim_in   = calc_limit(max_side);
                  cnt_in   = '0;
                  state_in = S_INIT;
               end
            end
         end
         S_TEST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_build_in = 1'b0;
               rsp_prime_in = !oor_ff && ram_rdata && shape_ff;
               rsp_oor_in   = oor_ff;
               rsp_norm_in  = norm_ff;
               state_in     = S_IDLE;
            end
         end
         S_INIT: begin
            // mark everything from two upward as a candidate prime
            if (cnt_below) begin
               ram_we    = 1'b1;
               ram_wdata = cnt_ff >= (LIMIT_W+1)'(2);
               cnt_in    = cnt_ff + (LIMIT_W+1)'(1);
            end else begin
               idx_in   = LIMIT_W'(2);
               sq_in    = (LIMIT_W+1)'(4);
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (sq_ff < {1'b0, lim_ff}) begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff[ADDR_W-1:0];
               state_in  = S_CHECK;
            end else begin
               limit_in = lim_ff;
               state_in = S_DONE;
            end
         end
         S_CHECK: begin
            if (ram_rdata) begin
               cnt_in   = sq_ff;
               state_in = S_STRIKE;
            end else begin
               idx_in   = idx_ff + LIMIT_W'(1);
               sq_in    = sq_ff + {idx_ff, 1'b0} + (LIMIT_W+1)'(1);
               state_in = S_PICK;
            end
         end
         S_STRIKE: begin
            // clear every multiple from the square upward
            if (cnt_below) begin
               ram_we = 1'b1;
               cnt_in = cnt_ff + (LIMIT_W+1)'(idx_ff);
            end else begin
               idx_in   = idx_ff + LIMIT_W'(1);
               sq_in    = sq_ff + {idx_ff, 1'b0} + (LIMIT_W+1)'(1);
               state_in = S_PICK;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_build_in = 1'b1;
               rsp_prime_in = 1'b0;
               rsp_oor_in   = 1'b0;
               rsp_norm_in  = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lim_ff       <= lim_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      sq_ff        <= sq_in;
      oor_ff       <= oor_in;
      shape_ff     <= shape_in;
      norm_ff      <= norm_in;
      rsp_build_ff <= rsp_build_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_oor_ff   <= rsp_oor_in;
      rsp_norm_ff  <= rsp_norm_in;
   end

   assign req_if.ready             = (state_ff == S_IDLE);
   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.build_done        = rsp_build_ff;
   assign rsp_if.is_gaussian_prime = rsp_prime_ff;
   assign rsp_if.out_of_range      = rsp_oor_ff;
   assign rsp_if.norm_value        = rsp_norm_ff;
   assign sieved_limit             = limit_ff;

   `GPST_ASSERT_NEXT(a_test_enters_lookup, req_accept && req_if.action == ACT_TEST,
      state_ff == S_TEST, "accepted test did not enter lookup")
   `GPST_ASSERT_IMPL(a_no_write_on_lookup, state_ff == S_TEST || state_ff == S_IDLE,
      !ram_we, "bitmap written outside a build")
   `GPST_ASSERT_IMPL(a_write_below_limit, ram_we, cnt_ff < {1'b0, lim_ff},
      "bitmap write beyond sieve range")
   `GPST_ASSERT_IMPL(a_limit_moves_at_end, !$stable(limit_ff),
      $past(state_ff) == S_PICK, "sieved limit changed outside build end")

endmodule

// ===== rtl/gaussian_prime_sieve_tester_top.sv =====
// Top level of the Gaussian prime sieve tester.
// A build transaction (action 0) sieves 0 .. L-1 into a one-bit primality bitmap, with
// L = 2*n*n from the max_side register (n clamped to MAX_SIDE, L to BITMAP_DEPTH), and
// answers with build_done once done; a new max_side counts from the next build on.
// A build presets the bitmap, then reads each index i with i*i < L and, for each prime
// found, strikes its multiples from i*i upward before going on to the next index. A
// test transaction (action 1) forms the norm and issues the bitmap read, then takes the
// registered read data. Tests before any build report out_of_range. The block takes one
// transaction at a time; a finished response waits in its output register while the
// next request is accepted.
module gaussian_prime_sieve_tester_top import gpst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   gpst_req_if.sink         req_if,
   gpst_rsp_if.source       rsp_if,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata
);

   logic [CFG_W-1:0]   max_side_ff;
   logic [LIMIT_W-1:0] sieved_limit;
   norm_info_type      info;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic               ram_wdata;
   logic               ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic               ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_side_ff <= CFG_RESET;
      end else if (csr_we) begin
         max_side_ff <= csr_wdata;
      end
   end

   gpst_norm u_norm (
      .real_part    (req_if.real_part),
      .imag_part    (req_if.imag_part),
      .sieved_limit (sieved_limit),
      .info         (info)
   );

   gpst_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .max_side     (max_side_ff),
      .info         (info),
      .sieved_limit (sieved_limit),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata)
   );

   gpst_ram #(
      .WIDTH (1),
      .DEPTH (BITMAP_DEPTH)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule
